/* rtl/core/key_debounce_event_fifo_unit_defines.svh */
// ----------------------------------------------------------------------------
// key debounce event fifo assertion macros
// clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_EVENT_FIFO_UNIT_DEFINES_SVH
`define KEY_DEBOUNCE_EVENT_FIFO_UNIT_DEFINES_SVH

// property that must hold at every edge
`define KDEF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define KDEF_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/kdef_pkg.sv */
// ----------------------------------------------------------------------------
// kdef_pkg
// shared types, widths and code helpers of the key debounce event fifo
// ----------------------------------------------------------------------------
`default_nettype none

package kdef_pkg;

  localparam int unsigned NUM_KEYS_DEF           = 10;
  localparam int unsigned FILTER_TICKS_DEF       = 5;
  localparam int unsigned QUEUE_DEPTH_DEF        = 16;
  localparam int unsigned DEFAULT_LONG_TICKS_DEF = 100;

  localparam int unsigned LEVEL_LANES = 10;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned KEY_IDX_W   = 4;
  localparam int unsigned LONG_W      = 16;
  localparam int unsigned RPT_W       = 8;
  localparam int unsigned CODE_W      = 5;
  localparam int unsigned FILT_W      = 4;
  localparam int unsigned S_TDATA_W   = 40;
  localparam int unsigned M_TDATA_W   = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_SCAN  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_SET   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_LONG    = 2'd3
  } ev_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_READ
  } bk_state_e;

  // one classified request handed from the front to the back
  typedef struct packed {
    cmd_e                   op;
    logic [LEVEL_LANES-1:0] levels;
    logic [KEY_IDX_W-1:0]   key_idx;
    logic [LONG_W-1:0]      long_time;
    logic [RPT_W-1:0]       repeat_speed;
  } cmd_t;

  // event code 3*key + kind, kept to the low code bits
  function automatic logic [CODE_W-1:0] key_code_f(input logic [KEY_IDX_W-1:0] key,
                                                   input ev_e ev);
    logic [5:0] c;
    c = 6'({2'b00, key}) + 6'({1'b0, key, 1'b0}) + 6'({4'b0000, ev});
    return c[CODE_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/kdef_ram.sv */
// ----------------------------------------------------------------------------
// kdef_ram
// generic single write port ram with a registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module kdef_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/kdef_front.sv */
// ----------------------------------------------------------------------------
// kdef_front
// accepts requests, decodes and filters them, two-entry queue to the back
// ----------------------------------------------------------------------------
`default_nettype none

module kdef_front
  import kdef_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_valid_i,
  output logic                      s_ready_o,
  input  wire logic [S_TDATA_W-1:0] s_tdata_i,
  input  wire logic [CMD_W-1:0]     s_tuser_i,
  output logic                      cmd_valid_o,
  output cmd_t                      cmd_o,
  input  wire logic                 cmd_ready_i
);

  cmd_t       dec;
  logic       keep;
  logic       push;
  logic       pop;
  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  // unpack the request
  always_comb begin
    dec.op           = cmd_e'(s_tuser_i);
    dec.levels       = s_tdata_i[9:0];
    dec.key_idx      = s_tdata_i[13:10];
    dec.long_time    = s_tdata_i[29:14];
    dec.repeat_speed = s_tdata_i[37:30];
  end

  // a set on a key that does not exist has no effect at all
  assign keep = !((dec.op == CMD_SET) && ({1'b0, dec.key_idx} >= 5'(NUM_KEYS)));

  assign s_ready_o   = (cnt_q != 2'd2);
  assign push        = s_valid_i && s_ready_o && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= dec;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/kdef_back.sv */
// ----------------------------------------------------------------------------
// kdef_back
// sequencer: walks the keys on a scan tick, keeps the code ring, serves reads
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_debounce_event_fifo_unit_defines.svh"

module kdef_back
  import kdef_pkg::*;
#(
  parameter int unsigned NUM_KEYS           = NUM_KEYS_DEF,
  parameter int unsigned FILTER_TICKS       = FILTER_TICKS_DEF,
  parameter int unsigned QUEUE_DEPTH        = QUEUE_DEPTH_DEF,
  parameter int unsigned DEFAULT_LONG_TICKS = DEFAULT_LONG_TICKS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cmd_valid_i,
  input  wire cmd_t                   cmd_i,
  output logic                        cmd_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [CODE_W-1:0]           out_code_o,
  output logic [LEVEL_LANES-1:0]      out_states_o
);

  localparam int unsigned KIDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned KCNT_W = $clog2(NUM_KEYS + 1);
  localparam int unsigned QW     = $clog2(QUEUE_DEPTH);
  localparam logic [QW-1:0] QLAST = QW'(QUEUE_DEPTH - 1);

  function automatic logic [QW-1:0] ring_next(input logic [QW-1:0] p);
    return (p == QLAST) ? '0 : p + 1'b1;
  endfunction

  bk_state_e              state_q, state_d;
  logic [KCNT_W-1:0]      key_q, key_d;
  logic [LEVEL_LANES-1:0] levels_q, levels_d;
  logic                   pend_v_q, pend_v_d;
  logic [CODE_W-1:0]      pend_code_q, pend_code_d;
  logic [QW-1:0]          head_q, head_d;
  logic [QW-1:0]          tail_q, tail_d;
  logic                   rd_empty_q, rd_empty_d;
  logic                   out_v_q, out_v_d;
  logic [CODE_W-1:0]      out_code_q, out_code_d;
  logic [LEVEL_LANES-1:0] out_states_q, out_states_d;

  // per-key state
  logic [FILT_W-1:0]   filt_q [NUM_KEYS];
  logic [NUM_KEYS-1:0] dbs_q;
  logic [LONG_W-1:0]   hold_q [NUM_KEYS];
  logic [RPT_W-1:0]    rcnt_q [NUM_KEYS];
  logic [LONG_W-1:0]   lim_q  [NUM_KEYS];
  logic [RPT_W-1:0]    per_q  [NUM_KEYS];

  logic [KIDX_W-1:0]      kidx;
  logic [KIDX_W-1:0]      sidx;
  logic [15:0]            lv_ext;
  logic                   raw;
  logic [FILT_W-1:0]      f_n;
  logic                   d_n;
  logic [LONG_W-1:0]      h_n;
  logic [RPT_W-1:0]       r_n;
  logic                   ev_a_v, ev_b_v;
  ev_e                    ev_b;
  logic                   first_v, sec_v;
  logic [CODE_W-1:0]      first_code, sec_code;
  logic                   key_we, set_we;
  logic                   push_v;
  logic [CODE_W-1:0]      push_code;
  logic                   q_full;
  logic                   ram_we, ram_re;
  logic [CODE_W-1:0]      ram_rdata;
  logic [LEVEL_LANES-1:0] states_vec;
  logic                   cmd_ready;

  assign kidx   = key_q[KIDX_W-1:0];
  assign sidx   = cmd_i.key_idx[KIDX_W-1:0];
  assign lv_ext = 16'(levels_q);
  assign raw    = lv_ext[4'(kidx)];

  // one debounce step of the current key
  always_comb begin
    f_n    = filt_q[kidx];
    d_n    = dbs_q[kidx];
    h_n    = hold_q[kidx];
    r_n    = rcnt_q[kidx];
    ev_a_v = 1'b0;
    ev_b_v = 1'b0;
    ev_b   = EV_LONG;
    if (raw) begin
      if (filt_q[kidx] < FILT_W'(FILTER_TICKS)) begin
        f_n = FILT_W'(FILTER_TICKS);
      end else if (filt_q[kidx] < FILT_W'(2 * FILTER_TICKS)) begin
        f_n = filt_q[kidx] + 1'b1;
      end else begin
        if (!dbs_q[kidx]) begin
          d_n    = 1'b1;
          ev_a_v = 1'b1;
        end
        if (lim_q[kidx] != '0) begin
          if (hold_q[kidx] < lim_q[kidx]) begin
            h_n = hold_q[kidx] + 1'b1;
            if (h_n == lim_q[kidx]) begin
              ev_b_v = 1'b1;
              ev_b   = EV_LONG;
            end
          end else if (per_q[kidx] != '0) begin
            r_n = rcnt_q[kidx] + 1'b1;
            if (r_n >= per_q[kidx]) begin
              r_n    = '0;
              ev_b_v = 1'b1;
              ev_b   = EV_PRESS;
            end
          end
        end
      end
    end else begin
      if (filt_q[kidx] > FILT_W'(FILTER_TICKS)) begin
        f_n = FILT_W'(FILTER_TICKS);
      end else if (filt_q[kidx] != '0) begin
        f_n = filt_q[kidx] - 1'b1;
      end else if (dbs_q[kidx]) begin
        d_n    = 1'b0;
        ev_a_v = 1'b1;
      end
      h_n = '0;
      r_n = '0;
    end
  end

  // press or release goes first, long or repeat code second
  always_comb begin
    first_v    = ev_a_v || ev_b_v;
    sec_v      = ev_a_v && ev_b_v;
    first_code = ev_a_v ? key_code_f(4'(kidx), raw ? EV_PRESS : EV_RELEASE)
                        : key_code_f(4'(kidx), ev_b);
    sec_code   = key_code_f(4'(kidx), ev_b);
  end

  for (genvar g = 0; g < LEVEL_LANES; g++) begin : g_states
    if (g < NUM_KEYS) begin : g_lane
      assign states_vec[g] = dbs_q[g];
    end else begin : g_none
      assign states_vec[g] = 1'b0;
    end
  end

  assign q_full = (ring_next(tail_q) == head_q);

  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    levels_d     = levels_q;
    pend_v_d     = pend_v_q;
    pend_code_d  = pend_code_q;
    head_d       = head_q;
    tail_d       = tail_q;
    rd_empty_d   = rd_empty_q;
    out_v_d      = out_v_q;
    out_code_d   = out_code_q;
    out_states_d = out_states_q;
    cmd_ready    = 1'b0;
    key_we       = 1'b0;
    set_we       = 1'b0;
    push_v       = 1'b0;
    push_code    = first_code;
    ram_re       = 1'b0;

    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end

    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            CMD_SCAN: begin
              cmd_ready = 1'b1;
              levels_d  = cmd_i.levels;
              key_d     = '0;
              pend_v_d  = 1'b0;
              state_d   = BK_SCAN;
            end
            CMD_READ: begin
              if (!out_v_q) begin
                cmd_ready  = 1'b1;
                ram_re     = 1'b1;
                rd_empty_d = (head_q == tail_q);
                state_d    = BK_READ;
              end
            end
            CMD_CLEAR: begin
              cmd_ready = 1'b1;
              head_d    = tail_q;
            end
            CMD_SET: begin
              cmd_ready = 1'b1;
              set_we    = 1'b1;
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (pend_v_q) begin
          push_v    = 1'b1;
          push_code = pend_code_q;
          pend_v_d  = 1'b0;
        end else if (key_q == KCNT_W'(NUM_KEYS)) begin
          state_d = BK_IDLE;
        end else begin
          key_we      = 1'b1;
          push_v      = first_v;
          push_code   = first_code;
          pend_v_d    = sec_v;
          pend_code_d = sec_code;
          key_d       = key_q + 1'b1;
        end
      end
      BK_READ: begin
        out_v_d      = 1'b1;
        out_code_d   = rd_empty_q ? '0 : ram_rdata;
        out_states_d = states_vec;
        if (!rd_empty_q) begin
          head_d = ring_next(head_q);
        end
        state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    // a code for a full ring is dropped
    ram_we = push_v && !q_full;
    if (ram_we) begin
      tail_d = ring_next(tail_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      key_q      <= '0;
      pend_v_q   <= 1'b0;
      head_q     <= '0;
      tail_q     <= '0;
      rd_empty_q <= 1'b1;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      key_q      <= key_d;
      pend_v_q   <= pend_v_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      rd_empty_q <= rd_empty_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    levels_q     <= levels_d;
    pend_code_q  <= pend_code_d;
    out_code_q   <= out_code_d;
    out_states_q <= out_states_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbs_q <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        filt_q[k] <= FILT_W'(FILTER_TICKS / 2);
        hold_q[k] <= '0;
        rcnt_q[k] <= '0;
        lim_q[k]  <= LONG_W'(DEFAULT_LONG_TICKS);
        per_q[k]  <= '0;
      end
    end else if (key_we) begin
      filt_q[kidx] <= f_n;
      dbs_q[kidx]  <= d_n;
      hold_q[kidx] <= h_n;
      rcnt_q[kidx] <= r_n;
    end else if (set_we) begin
      lim_q[sidx]  <= cmd_i.long_time;
      per_q[sidx]  <= cmd_i.repeat_speed;
      rcnt_q[sidx] <= '0;
    end
  end

  kdef_ram #(
    .WIDTH (CODE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (push_code),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign cmd_ready_o  = cmd_ready;
  assign out_valid_o  = out_v_q;
  assign out_code_o   = out_code_q;
  assign out_states_o = out_states_q;

  `KDEF_ASSERT(a_ptr_range, (head_q <= QLAST) && (tail_q <= QLAST), "ring pointer out of range")
  `KDEF_ASSERT_NEXT(a_read_done, state_q == BK_READ, out_v_q && state_q == BK_IDLE, "read stuck")
  `KDEF_ASSERT(a_pend_scan, !pend_v_q || (state_q == BK_SCAN), "code pending outside a scan")
  `KDEF_ASSERT(a_key_bound, key_q <= KCNT_W'(NUM_KEYS), "key walk past the last key")

endmodule

`default_nettype wire

/* rtl/core/key_debounce_event_fifo_unit.sv */
// a read result is registered: a taken read passes the BK_READ state, then the output register,
//   and a read request is taken only while no result is held (empty output)
// throughput: a scan tick occupies the back sequencer while it walks the keys one per cycle,
//   with an extra step for each key that queues two codes in that tick
// clear and set are handled in the idle state; a read also passes the BK_READ state for the ram read
// reset: async active low; all keys released, filters at half, ring empty, no result valid
// ----------------------------------------------------------------------------
// key_debounce_event_fifo_unit
// debounces key levels on scan ticks, queues press, release, long and repeat
// codes in a ring and pops one code per read request
// ----------------------------------------------------------------------------
`default_nettype none

module key_debounce_event_fifo_unit
  import kdef_pkg::*;
#(
  parameter int unsigned NUM_KEYS           = NUM_KEYS_DEF,
  parameter int unsigned FILTER_TICKS       = FILTER_TICKS_DEF,
  parameter int unsigned QUEUE_DEPTH        = QUEUE_DEPTH_DEF,
  parameter int unsigned DEFAULT_LONG_TICKS = DEFAULT_LONG_TICKS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // request channel
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // key_levels[9:0], key_index[13:10], long_time[29:14], repeat_speed[37:30], zero[39:38]
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // cmd[1:0]: scan tick, read one code, clear queue, set key parameters
  input  wire logic [CMD_W-1:0]     s_axis_tuser,
  // result channel, one item per read request
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // key_code[4:0], pressed_states[14:5], zero[15]
  output logic [M_TDATA_W-1:0]      m_axis_tdata
);

  // classified requests between front and back
  cmd_t                   cmd;
  logic                   cmd_valid;
  logic                   cmd_ready;
  logic [CODE_W-1:0]      out_code;
  logic [LEVEL_LANES-1:0] out_states;

  // front: decode, drop sets on missing keys, buffer two requests
  kdef_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // back: key walk, code ring in ram, output register
  kdef_back #(
    .NUM_KEYS           (NUM_KEYS),
    .FILTER_TICKS       (FILTER_TICKS),
    .QUEUE_DEPTH        (QUEUE_DEPTH),
    .DEFAULT_LONG_TICKS (DEFAULT_LONG_TICKS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_ready_o  (cmd_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_code_o   (out_code),
    .out_states_o (out_states)
  );

  // pack the result, code in the low bits
  assign m_axis_tdata = {1'b0, out_states, out_code};

endmodule

`default_nettype wire

/* tb/sv/key_debounce_event_fifo_unit_tb.sv */
// ----------------------------------------------------------------------------
// key_debounce_event_fifo_unit_tb
// drives scan, read, clear and set requests into the key debounce event fifo,
// mirrors the filters, hold and repeat counters and the code ring in a local
// model, and checks every popped code and pressed-state vector in order
// ----------------------------------------------------------------------------
`default_nettype none

module key_debounce_event_fifo_unit_tb;
  import kdef_pkg::*;

  localparam int unsigned NKEYS        = NUM_KEYS_DEF;
  localparam int unsigned FILT         = FILTER_TICKS_DEF;
  localparam int unsigned QDEPTH       = QUEUE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned MAX_SHOWN    = 40;

  // one popped code with the debounced states seen by the read
  typedef struct packed {
    logic [CODE_W-1:0]      code;
    logic [LEVEL_LANES-1:0] states;
  } read_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // key_levels[9:0], key_index[13:10], long_time[29:14], repeat_speed[37:30], zero[39:38]
  logic [S_TDATA_W-1:0] s_axis_tdata;
  // cmd[1:0]
  logic [CMD_W-1:0]     s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // key_code[4:0], pressed_states[14:5], zero[15]
  logic [M_TDATA_W-1:0] m_axis_tdata;

  key_debounce_event_fifo_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // ---------------------------------------------------------------------------
  // local copy of the key state and the code ring
  // ---------------------------------------------------------------------------
  int unsigned       flt_cnt    [NKEYS];
  bit                key_down   [NKEYS];
  logic [LONG_W-1:0] hold_ticks [NKEYS];
  logic [RPT_W-1:0]  rpt_ticks  [NKEYS];
  logic [LONG_W-1:0] long_lim   [NKEYS];
  logic [RPT_W-1:0]  rpt_per    [NKEYS];
  logic [CODE_W-1:0] code_ring  [QDEPTH];
  int unsigned       ring_rd;
  int unsigned       ring_wr;

  // expected results of accepted read requests, oldest first
  read_result_t pending_reads[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned requests_sent;
  int unsigned scans_seen;
  int unsigned reads_checked;
  int unsigned codes_queued;
  int unsigned codes_dropped;

  function automatic void reset_key_model();
    for (int k = 0; k < NKEYS; k++) begin
      flt_cnt[k]    = FILT / 2;
      key_down[k]   = 1'b0;
      hold_ticks[k] = '0;
      rpt_ticks[k]  = '0;
      long_lim[k]   = LONG_W'(DEFAULT_LONG_TICKS_DEF);
      rpt_per[k]    = '0;
    end
    for (int q = 0; q < QDEPTH; q++) code_ring[q] = '0;
    ring_rd = 0;
    ring_wr = 0;
  endfunction

  // the ring keeps one slot free; a code for a full ring is lost
  function automatic void push_key_code(int unsigned key, ev_e ev);
    int unsigned nxt;
    nxt = (ring_wr + 1 >= QDEPTH) ? 0 : ring_wr + 1;
    if (nxt == ring_rd) begin
      codes_dropped++;
      return;
    end
    code_ring[ring_wr] = CODE_W'(3 * key + int'(ev));
    ring_wr = nxt;
    codes_queued++;
  endfunction

  // hysteresis filter, then press, long press and auto-repeat of one key
  function automatic void scan_one_key(int unsigned k, bit raw);
    if (raw) begin
      if (flt_cnt[k] < FILT) begin
        flt_cnt[k] = FILT;
      end else if (flt_cnt[k] < 2 * FILT) begin
        flt_cnt[k]++;
      end else begin
        if (!key_down[k]) begin
          key_down[k] = 1'b1;
          push_key_code(k, EV_PRESS);
        end
        if (long_lim[k] != 0) begin
          if (hold_ticks[k] < long_lim[k]) begin
            hold_ticks[k]++;
            if (hold_ticks[k] == long_lim[k]) push_key_code(k, EV_LONG);
          end else if (rpt_per[k] != 0) begin
            rpt_ticks[k]++;
            if (rpt_ticks[k] >= rpt_per[k]) begin
              rpt_ticks[k] = '0;
              push_key_code(k, EV_PRESS);
            end
          end
        end
      end
    end else begin
      if (flt_cnt[k] > FILT) begin
        flt_cnt[k] = FILT;
      end else if (flt_cnt[k] != 0) begin
        flt_cnt[k]--;
      end else if (key_down[k]) begin
        key_down[k] = 1'b0;
        push_key_code(k, EV_RELEASE);
      end
      hold_ticks[k] = '0;
      rpt_ticks[k]  = '0;
    end
  endfunction

  // update the local state for one accepted request
  function automatic void debounce_and_queue(cmd_e op, logic [LEVEL_LANES-1:0] lv,
                                             logic [KEY_IDX_W-1:0] idx,
                                             logic [LONG_W-1:0] lt, logic [RPT_W-1:0] rs);
    read_result_t res;
    case (op)
      CMD_SCAN: begin
        scans_seen++;
        for (int k = 0; k < NKEYS; k++) scan_one_key(k, (k < LEVEL_LANES) ? lv[k] : 1'b0);
      end
      CMD_READ: begin
        res = '0;
        if (ring_rd != ring_wr) begin
          res.code = code_ring[ring_rd];
          ring_rd  = (ring_rd + 1 >= QDEPTH) ? 0 : ring_rd + 1;
        end
        for (int k = 0; k < NKEYS && k < LEVEL_LANES; k++) res.states[k] = key_down[k];
        pending_reads.push_back(res);
      end
      CMD_CLEAR: begin
        ring_rd = ring_wr;
      end
      default: begin
        // a set on a key that does not exist is ignored
        if (idx < NKEYS) begin
          long_lim[idx]  = lt;
          rpt_per[idx]   = rs;
          rpt_ticks[idx] = '0;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("mismatch at cycle %0d: %s got %0d expected %0d",
               cycle_count, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // clock, cycle limit, receiver stalls
  // ---------------------------------------------------------------------------
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d reads outstanding",
               cycle_count, pending_reads.size());
      $display("key_debounce_event_fifo_unit_tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // result check first, then the request taken at the same edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    read_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_reads.size() == 0) begin
          report_mismatch("result with no read pending, tdata", m_axis_tdata, 0);
        end else begin
          want = pending_reads.pop_front();
          reads_checked++;
          if (m_axis_tdata[CODE_W-1:0] !== want.code)
            report_mismatch("key_code", m_axis_tdata[CODE_W-1:0], want.code);
          if (m_axis_tdata[CODE_W +: LEVEL_LANES] !== want.states)
            report_mismatch("pressed_states", m_axis_tdata[CODE_W +: LEVEL_LANES],
                            want.states);
          if (m_axis_tdata[M_TDATA_W-1] !== 1'b0)
            report_mismatch("pad bit", m_axis_tdata[M_TDATA_W-1], 0);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        debounce_and_queue(cmd_e'(s_axis_tuser), s_axis_tdata[9:0], s_axis_tdata[13:10],
                           s_axis_tdata[29:14], s_axis_tdata[37:30]);
    end
  end

  // ---------------------------------------------------------------------------
  // request driver: entered and left on a falling edge, valid held between
  // back-to-back requests
  // ---------------------------------------------------------------------------
  task automatic send_request(input cmd_e op, input logic [LEVEL_LANES-1:0] lv,
                              input logic [KEY_IDX_W-1:0] idx, input logic [LONG_W-1:0] lt,
                              input logic [RPT_W-1:0] rs);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, rs, lt, idx, lv};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    requests_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // empty ring after reset: code 0 and every key released
  task automatic test_power_on_read();
    send_request(CMD_READ, LEVEL_LANES'($urandom), '0, '0, '0);
  endtask

  // two keys with long time 1 give press and long in one tick, then a repeat
  // every tick, until the ring runs full and codes are dropped
  task automatic test_press_long_repeat_overflow();
    send_request(CMD_SET, '0, 4'd0, 16'd1, 8'd1);
    send_request(CMD_SET, '0, 4'd1, 16'd1, 8'd1);
    send_request(CMD_SET, '0, 4'd9, 16'hFFFF, 8'hFF);
    send_request(CMD_SET, '0, 4'd3, 16'd0, 8'd0);
    // key index past the last key, must not touch any key
    send_request(CMD_SET, '1, 4'd15, 16'hFFFF, 8'hFF);
    repeat (9) send_request(CMD_SCAN, '1, '0, '0, '0);
    send_request(CMD_READ, '0, '1, '1, '1);
  endtask

  // clear empties the ring, then all keys go through release filtering
  task automatic test_clear_and_release();
    send_request(CMD_CLEAR, '1, '1, '1, '1);
    send_request(CMD_READ, '0, '0, '0, '0);
    repeat (7) send_request(CMD_SCAN, '0, '1, '1, '1);
    send_request(CMD_READ, '0, '0, '0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // random traffic: key patterns held for runs of ticks with contact bounce,
  // reads to drain the ring, sets with mostly short long and repeat times
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned            sent;
    int unsigned            pick;
    int unsigned            run_left;
    logic [LEVEL_LANES-1:0] held;
    logic [LEVEL_LANES-1:0] lv;
    logic [KEY_IDX_W-1:0]   idx;
    logic [LONG_W-1:0]      lt;
    logic [RPT_W-1:0]       rs;
    sent     = 0;
    run_left = 0;
    held     = '0;
    while (sent < n_items) begin
      lv   = LEVEL_LANES'($urandom);
      idx  = KEY_IDX_W'($urandom);
      lt   = LONG_W'($urandom);
      rs   = RPT_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 50) begin
        if (run_left == 0) begin
          // mostly toggle a few keys, sometimes jump to a fresh pattern
          if ($urandom_range(9) == 0) held = LEVEL_LANES'($urandom);
          else held = held ^ (LEVEL_LANES'($urandom) & LEVEL_LANES'($urandom));
          run_left = $urandom_range(30, 1);
        end
        run_left--;
        lv = held;
        if ($urandom_range(99) < 15) lv[$urandom_range(LEVEL_LANES - 1)] ^= 1'b1;
        send_request(CMD_SCAN, lv, idx, lt, rs);
        sent++;
      end else if (pick < 88) begin
        send_request(CMD_READ, lv, idx, lt, rs);
        sent++;
      end else if (pick < 96) begin
        pick = $urandom_range(99);
        if (pick < 10) lt = '0;
        else if (pick < 65) lt = LONG_W'($urandom_range(12, 1));
        else if (pick < 85) lt = LONG_W'($urandom_range(300, 13));
        else if (pick < 95) lt = LONG_W'($urandom);
        else lt = '1;
        pick = $urandom_range(99);
        if (pick < 20) rs = '0;
        else if (pick < 70) rs = RPT_W'($urandom_range(4, 1));
        else if (pick < 90) rs = RPT_W'($urandom_range(40, 5));
        else rs = '1;
        send_request(CMD_SET, lv, idx, lt, rs);
        if (idx < NKEYS) sent++;
      end else begin
        send_request(CMD_CLEAR, lv, idx, lt, rs);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_SCAN;
    m_axis_tready = 1'b0;
    send_idle_pct = 15;
    recv_idle_pct = 55;
    mismatches    = 0;
    cycle_count   = 0;
    requests_sent = 0;
    scans_seen    = 0;
    reads_checked = 0;
    codes_queued  = 0;
    codes_dropped = 0;
    reset_key_model();

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_power_on_read();
    test_press_long_repeat_overflow();
    test_clear_and_release();

    // sender idles lightly while the result side stalls often
    test_random_traffic(510);
    // and the other way round
    send_idle_pct = 55;
    recv_idle_pct = 15;
    test_random_traffic(510);
    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(510);

    s_axis_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(negedge clk_i);
    // a final scan tick may still be walking the keys
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d requests, %0d scan ticks and %0d checked reads",
             requests_sent, scans_seen, reads_checked);
    $display("%0d key codes queued, %0d lost on a full ring, %0d mismatches",
             codes_queued, codes_dropped, mismatches);
    if (mismatches == 0) begin
      $display("key_debounce_event_fifo_unit_tb: PASS");
    end else begin
      $display("key_debounce_event_fifo_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/kdef_pkg.sv
rtl/core/kdef_ram.sv
rtl/core/kdef_front.sv
rtl/core/kdef_back.sv
rtl/core/key_debounce_event_fifo_unit.sv
tb/sv/key_debounce_event_fifo_unit_tb.sv
